/* hw/rtl/plp_pkg.sv */
// Shared types and constants of the provisioning line parser.
package plp_pkg;

    typedef enum logic [2:0] {
        PH_PREFIX  = 3'd0,
        PH_SLOT    = 3'd1,
        PH_KEY     = 3'd2,
        PH_COUNTER = 3'd3,
        PH_NAME    = 3'd4
    } phase_t;

    localparam logic [1:0] ST_RECORD    = 2'd0;
    localparam logic [1:0] ST_MALFORMED = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;
    localparam logic [1:0] ST_TIMEOUT   = 2'd3;

    localparam int NAME_BYTES = 24;

    localparam logic [7:0] CH_LF      = 8'h0a;
    localparam logic [7:0] CH_CR      = 8'h0d;
    localparam logic [7:0] CH_COLON   = 8'h3a;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2b;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    // Result request (line end, overflow or timeout) handed from the parser to the output stage.
    typedef struct packed {
        logic        valid;
        logic [1:0]  status;
        logic [3:0]  slot;
        logic [31:0] counter;
        logic [127:0] key;
        logic [191:0] name;
    } result_t;

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd16;
        if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h57);
        else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h37);
        return v;
    endfunction

    function automatic logic [7:0] prefix_char(input logic [2:0] i);
        logic [7:0] r;
        unique case (i)
            3'd0: r = 8'h50;
            3'd1: r = 8'h52;
            3'd2: r = 8'h4f;
            3'd3: r = 8'h56;
            3'd4: r = 8'h3a;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

/* hw/rtl/plp_parser.sv */
// Per-character parse state and line-end result formation.
module plp_parser #(
    parameter int SLOT_COUNT    = 4,
    parameter int LINE_CAPACITY = 128
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              func,
    input  logic [7:0]        rx_byte,
    input  logic              res_ready,
    output plp_pkg::result_t  res
);
    localparam int LW = $clog2(LINE_CAPACITY);

    logic [LW-1:0]     len_reg, len_next;
    plp_pkg::phase_t   ph_reg, ph_next;
    logic [5:0]        pos_reg, pos_next;
    logic              mal_reg, mal_next;
    logic              end_reg, end_next;
    logic [3:0]        slot_reg, slot_next;
    logic [127:0]      key_reg, key_next;
    logic [31:0]       cnt_reg, cnt_next;
    logic [191:0]      name_reg, name_next;
    logic [4:0]        nc_reg, nc_next;
    logic [7:0]        pend_reg, pend_next;
    logic [1:0]        esc_reg, esc_next;
    plp_pkg::result_t  res_next;

    // Local working copies for name decoding
    logic [191:0] wn;
    logic [4:0]   wc;
    logic [1:0]   we;
    logic [7:0]   wp;

    function automatic void put(inout logic [191:0] n, inout logic [4:0] k,
                                input logic [7:0] b);
        if (k < 5'd24)
        begin
            n[8'(191 - 8 * k) -: 8] = b;
            k = k + 5'd1;
        end
    endfunction

    function automatic void plain(inout logic [191:0] n, inout logic [4:0] k,
                                  inout logic [1:0] e, input logic [7:0] c);
        if (c == plp_pkg::CH_PERCENT) e = 2'd1;
        else if (c == plp_pkg::CH_PLUS) put(n, k, plp_pkg::CH_SPACE);
        else put(n, k, c);
    endfunction

    function automatic void finish(inout logic [191:0] n, inout logic [4:0] k,
                                   inout logic [1:0] e, inout logic [7:0] p);
        if (e == 2'd1) put(n, k, plp_pkg::CH_PERCENT);
        else if (e == 2'd2)
        begin
            put(n, k, plp_pkg::CH_PERCENT);
            e = 2'd0;
            plain(n, k, e, p);
            if (e == 2'd1) put(n, k, plp_pkg::CH_PERCENT);
        end
        e = 2'd0;
        p = 8'd0;
    endfunction

    always_comb
    begin
        logic [4:0] hv, h1;
        logic       clear;
        logic       is_eol;
        logic [7:0] sv;
        len_next = len_reg; ph_next = ph_reg; pos_next = pos_reg;
        mal_next = mal_reg; end_next = end_reg; slot_next = slot_reg;
        key_next = key_reg; cnt_next = cnt_reg;
        wn = name_reg; wc = nc_reg; we = esc_reg; wp = pend_reg;
        res_next = '0;
        clear = 1'b0;
        hv = plp_pkg::hex_val(rx_byte);
        h1 = plp_pkg::hex_val(pend_reg);
        sv = rx_byte - 8'h30;
        is_eol = (rx_byte == plp_pkg::CH_LF) || (rx_byte == plp_pkg::CH_CR);
        if (in_valid)
        begin
            if (func)
            begin
                if (len_reg == '0)
                begin
                    res_next.valid = 1'b1;
                    res_next.status = plp_pkg::ST_TIMEOUT;
                    clear = 1'b1;
                end
            end
            else if (is_eol)
            begin
                if (len_reg != '0)
                begin
                    if (!end_reg && !mal_reg && ph_reg == plp_pkg::PH_NAME)
                        finish(wn, wc, we, wp);
                    res_next.valid = 1'b1;
                    if (mal_reg || ph_reg != plp_pkg::PH_NAME)
                        res_next.status = plp_pkg::ST_MALFORMED;
                    else
                    begin
                        res_next.status = plp_pkg::ST_RECORD;
                        res_next.slot = slot_reg;
                        res_next.counter = cnt_reg;
                        res_next.key = key_reg;
                        res_next.name = wn;
                    end
                    clear = 1'b1;
                end
            end
            else
            begin
                len_next = len_reg + 1'b1;
                if (!mal_reg && !end_reg)
                begin
                    if (rx_byte == 8'd0)
                    begin
                        end_next = 1'b1;
                        if (ph_reg == plp_pkg::PH_NAME) finish(wn, wc, we, wp);
                    end
                    else
                    begin
                        unique case (ph_reg)
                            plp_pkg::PH_PREFIX:
                                if (pos_reg > 6'd4 ||
                                    rx_byte != plp_pkg::prefix_char(pos_reg[2:0]))
                                    mal_next = 1'b1;
                                else if (pos_reg == 6'd4)
                                begin
                                    ph_next = plp_pkg::PH_SLOT;
                                    pos_next = '0;
                                end
                                else pos_next = pos_reg + 6'd1;
                            plp_pkg::PH_SLOT:
                                if (pos_reg == 6'd0)
                                begin
                                    if (rx_byte == plp_pkg::CH_COLON ||
                                        sv >= 8'(SLOT_COUNT))
                                        mal_next = 1'b1;
                                    else
                                    begin
                                        slot_next = sv[3:0];
                                        pos_next = 6'd1;
                                    end
                                end
                                else if (rx_byte != plp_pkg::CH_COLON) mal_next = 1'b1;
                                else
                                begin
                                    ph_next = plp_pkg::PH_KEY;
                                    pos_next = '0;
                                end
                            plp_pkg::PH_KEY:
                                if (pos_reg < 6'd32)
                                begin
                                    if (hv[4]) mal_next = 1'b1;
                                    else
                                    begin
                                        if (pos_reg[4])
                                            key_next[63:0] = {key_reg[59:0], hv[3:0]};
                                        else
                                            key_next[127:64] = {key_reg[123:64], hv[3:0]};
                                        pos_next = pos_reg + 6'd1;
                                    end
                                end
                                else if (rx_byte != plp_pkg::CH_COLON) mal_next = 1'b1;
                                else
                                begin
                                    ph_next = plp_pkg::PH_COUNTER;
                                    pos_next = '0;
                                end
                            plp_pkg::PH_COUNTER:
                                if (pos_reg < 6'd8)
                                begin
                                    if (hv[4]) mal_next = 1'b1;
                                    else
                                    begin
                                        cnt_next = {cnt_reg[27:0], hv[3:0]};
                                        pos_next = pos_reg + 6'd1;
                                    end
                                end
                                else if (rx_byte != plp_pkg::CH_COLON) mal_next = 1'b1;
                                else
                                begin
                                    ph_next = plp_pkg::PH_NAME;
                                    pos_next = '0;
                                end
                            plp_pkg::PH_NAME:
                                if (esc_reg == 2'd0) plain(wn, wc, we, rx_byte);
                                else if (esc_reg == 2'd1)
                                begin
                                    wp = rx_byte;
                                    we = 2'd2;
                                end
                                else
                                begin
                                    we = 2'd0;
                                    wp = 8'd0;
                                    if (!h1[4] && !hv[4]) put(wn, wc, {h1[3:0], hv[3:0]});
                                    else
                                    begin
                                        put(wn, wc, plp_pkg::CH_PERCENT);
                                        plain(wn, wc, we, pend_reg);
                                        if (we == 2'd1)
                                        begin
                                            wp = rx_byte;
                                            we = 2'd2;
                                        end
                                        else plain(wn, wc, we, rx_byte);
                                    end
                                end
                            default: mal_next = 1'b1;
                        endcase
                    end
                end
                if ({1'b0, len_next} >= (LW + 1)'(LINE_CAPACITY - 1))
                begin
                    res_next = '0;
                    res_next.valid = 1'b1;
                    res_next.status = plp_pkg::ST_OVERFLOW;
                    clear = 1'b1;
                end
            end
        end
        name_next = wn; nc_next = wc; esc_next = we; pend_next = wp;
        if (clear)
        begin
            len_next = '0; ph_next = plp_pkg::PH_PREFIX; pos_next = '0;
            mal_next = 1'b0; end_next = 1'b0; slot_next = '0; key_next = '0;
            cnt_next = '0; name_next = '0; nc_next = '0; pend_next = '0;
            esc_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0; ph_reg <= plp_pkg::PH_PREFIX; pos_reg <= '0;
            mal_reg <= 1'b0; end_reg <= 1'b0; slot_reg <= '0; key_reg <= '0;
            cnt_reg <= '0; name_reg <= '0; nc_reg <= '0; pend_reg <= '0;
            esc_reg <= '0; res <= '0;
        end
        else
        begin
            len_reg <= len_next; ph_reg <= ph_next; pos_reg <= pos_next;
            mal_reg <= mal_next; end_reg <= end_next; slot_reg <= slot_next;
            key_reg <= key_next; cnt_reg <= cnt_next; name_reg <= name_next;
            nc_reg <= nc_next; pend_reg <= pend_next; esc_reg <= esc_next;
            // hold a result until the output stage takes it
            if (!res.valid || res_ready) res <= res_next;
        end
    end

    a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_next.valid |=> (len_reg == '0 && ph_reg == plp_pkg::PH_PREFIX))
        else $error("state not cleared after result");
    a_escape_range: assert property (@(posedge clk) disable iff (!rst_n)
        esc_reg != 2'd3) else $error("bad escape count");
    a_name_count: assert property (@(posedge clk) disable iff (!rst_n)
        nc_reg <= 5'd24) else $error("name count overrun");
endmodule

/* hw/rtl/plp_emitter.sv */
// Output queue: turns result requests into one or five result words.
module plp_emitter (
    input  logic              clk,
    input  logic              rst_n,
    input  plp_pkg::result_t  res,
    output logic              busy,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        status,
    output logic [3:0]        slot,
    output logic [31:0]       counter,
    output logic [2:0]        word_index,
    output logic [63:0]       data_word,
    output logic              last
);
    plp_pkg::result_t cur_reg;
    logic [2:0]       idx_reg;
    logic             rec;
    logic             fin;

    assign rec = cur_reg.status == plp_pkg::ST_RECORD;
    assign fin = !rec || idx_reg == 3'd4;
    assign out_valid = cur_reg.valid;
    assign busy = cur_reg.valid && !(out_ready && fin);
    assign status = cur_reg.status;
    assign slot = cur_reg.slot;
    assign counter = cur_reg.counter;
    assign word_index = idx_reg;
    assign last = fin;

    always_comb
    begin
        unique case (idx_reg)
            3'd0: data_word = cur_reg.key[127:64];
            3'd1: data_word = cur_reg.key[63:0];
            3'd2: data_word = cur_reg.name[191:128];
            3'd3: data_word = cur_reg.name[127:64];
            3'd4: data_word = cur_reg.name[63:0];
            default: data_word = '0;
        endcase
        if (!rec) data_word = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg <= '0;
            idx_reg <= '0;
        end
        else if (res.valid && !busy)
        begin
            cur_reg <= res;
            idx_reg <= '0;
        end
        else if (cur_reg.valid && out_ready)
        begin
            if (fin)
            begin
                cur_reg.valid <= 1'b0;
                idx_reg <= '0;
            end
            else idx_reg <= idx_reg + 3'd1;
        end
    end

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= 3'd4) else $error("word index out of range");
    a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !rec) |-> idx_reg == 3'd0) else $error("status with index");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && !res.valid) |=> out_valid) else $error("pending word lost");
endmodule

/* hw/rtl/provisioning_line_parser.sv */
// Top level of the provisioning line parser.
//
// Usage:
//   s_axis carries one request per character: tdata = rx_byte (8 bits),
//   tuser = func (1 = deadline expired event, 0 = character).
//   m_axis carries result words: tdata packs status, slot, counter,
//   word_index, data_word; tlast marks the final word of a line.
// Throughput: one character per cycle, back to back, while the output
//   side keeps up. A record leaves as five result words, a status as one.
// Output path: a line end, overflow or timeout shows its first word once
//   the accepted request has passed the parse register, then the
//   output register, when the output stage is free.
// Stall: while the output stage still holds undelivered words, plain
//   characters keep flowing; a second line-end result waits in the parse
//   register, and s_axis_tready drops until the output stage takes it.
// Reset: rst_n clears the parse state to an empty line in prefix phase
//   and empties the output stage.
module provisioning_line_parser #(
    parameter int SLOT_COUNT    = 4,
    parameter int LINE_CAPACITY = 128
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
    input  logic         s_axis_tuser,   // [0] func
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [111:0] m_axis_tdata,   // status, slot, counter, word_index, data_word
    output logic         m_axis_tlast    // last
);
    plp_pkg::result_t res;
    logic             busy;
    logic [1:0]       status;
    logic [3:0]       slot;
    logic [31:0]      counter;
    logic [2:0]       word_index;
    logic [63:0]      data_word;

    // Hold input only while a parsed result waits and the output stage
    // cannot take it this cycle.
    assign s_axis_tready = !res.valid || !busy;

    plp_parser #(.SLOT_COUNT(SLOT_COUNT), .LINE_CAPACITY(LINE_CAPACITY)) u_parser (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid && s_axis_tready),
        .func(s_axis_tuser), .rx_byte(s_axis_tdata),
        .res_ready(!busy), .res(res)
    );

    plp_emitter u_emitter (
        .clk(clk), .rst_n(rst_n), .res(res), .busy(busy),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .status(status), .slot(slot), .counter(counter),
        .word_index(word_index), .data_word(data_word), .last(m_axis_tlast)
    );

    assign m_axis_tdata = {7'd0, data_word, word_index, counter, slot, status};
endmodule

/* bench/provisioning_line_parser_test.sv */
// Testbench for the provisioning line parser: directed and random lines, checked by a scoreboard.
`timescale 1ns / 1ps

module provisioning_line_parser_test;

    localparam int SLOTS     = 4;
    localparam int LINE_CAP  = 128;
    localparam int STALL_MAX = 5000;   // cycles with no request moving on either side

    // One expected result word
    typedef struct {
        logic [1:0]  status;
        logic [3:0]  slot;
        logic [31:0] counter;
        logic [2:0]  word_index;
        logic [63:0] data_word;
        logic        last;
    } plp_word_t;

    // Scoreboard: shadows the parser state and keeps the expected result words.
    class line_scoreboard;
        plp_word_t       pending_words[$];
        int              errors;
        int              words_checked;
        int              records;
        int              statuses;
        int              line_len;
        plp_pkg::phase_t phase;
        int              fpos;
        bit              malformed;
        bit              text_ended;
        logic [7:0]      slot_v;
        logic [63:0]     key_w[2];
        logic [31:0]     counter_v;
        logic [7:0]      name_b[plp_pkg::NAME_BYTES];
        int              name_n;
        logic [7:0]      esc_byte;
        int              esc_n;

        function new();
            errors = 0;
            words_checked = 0;
            records = 0;
            statuses = 0;
            clear_line();
        endfunction

        function void clear_line();
            line_len = 0;
            phase = plp_pkg::PH_PREFIX;
            fpos = 0;
            malformed = 0;
            text_ended = 0;
            slot_v = '0;
            key_w[0] = '0;
            key_w[1] = '0;
            counter_v = '0;
            foreach (name_b[i]) name_b[i] = '0;
            name_n = 0;
            esc_byte = '0;
            esc_n = 0;
        endfunction

        function int hex_digit(logic [7:0] c);
            if (c >= "0" && c <= "9") return c - "0";
            if (c >= "a" && c <= "f") return c - "a" + 10;
            if (c >= "A" && c <= "F") return c - "A" + 10;
            return 16;
        endfunction

        function void name_put(logic [7:0] b);
            if (name_n < plp_pkg::NAME_BYTES)
            begin
                name_b[name_n] = b;
                name_n++;
            end
        endfunction

        function void name_plain(logic [7:0] c);
            if (c == plp_pkg::CH_PERCENT) esc_n = 1;
            else if (c == plp_pkg::CH_PLUS) name_put(plp_pkg::CH_SPACE);
            else name_put(c);
        endfunction

        function void name_char(logic [7:0] c);
            logic [7:0] first;
            int hi;
            int lo;
            if (esc_n == 0)
            begin
                name_plain(c);
            end
            else if (esc_n == 1)
            begin
                esc_byte = c;
                esc_n = 2;
            end
            else
            begin
                first = esc_byte;
                hi = hex_digit(first);
                lo = hex_digit(c);
                esc_n = 0;
                esc_byte = '0;
                if (hi < 16 && lo < 16)
                begin
                    name_put(8'(hi * 16 + lo));
                end
                else
                begin
                    // not an escape: keep the percent, decode the rest normally
                    name_put(plp_pkg::CH_PERCENT);
                    name_plain(first);
                    if (esc_n == 1)
                    begin
                        esc_byte = c;
                        esc_n = 2;
                    end
                    else
                    begin
                        name_plain(c);
                    end
                end
            end
        endfunction

        function void name_close();
            if (esc_n == 1)
            begin
                name_put(plp_pkg::CH_PERCENT);
            end
            else if (esc_n == 2)
            begin
                name_put(plp_pkg::CH_PERCENT);
                esc_n = 0;
                name_plain(esc_byte);
                if (esc_n == 1) name_put(plp_pkg::CH_PERCENT);
            end
            esc_n = 0;
            esc_byte = '0;
        endfunction

        function void parse_char(logic [7:0] c);
            logic [7:0] tag[5];
            logic [7:0] v;
            int n;
            tag = '{"P", "R", "O", "V", ":"};
            case (phase)
                plp_pkg::PH_PREFIX:
                begin
                    if (fpos > 4 || c != tag[fpos])
                    begin
                        malformed = 1;
                        return;
                    end
                    fpos++;
                    if (fpos == 5)
                    begin
                        phase = plp_pkg::PH_SLOT;
                        fpos = 0;
                    end
                end
                plp_pkg::PH_SLOT:
                begin
                    if (fpos == 0)
                    begin
                        v = c - "0";
                        if (c == plp_pkg::CH_COLON || v >= SLOTS)
                        begin
                            malformed = 1;
                            return;
                        end
                        slot_v = v;
                        fpos = 1;
                    end
                    else if (c != plp_pkg::CH_COLON) malformed = 1;
                    else
                    begin
                        phase = plp_pkg::PH_KEY;
                        fpos = 0;
                    end
                end
                plp_pkg::PH_KEY:
                begin
                    if (fpos < 32)
                    begin
                        n = hex_digit(c);
                        if (n >= 16)
                        begin
                            malformed = 1;
                            return;
                        end
                        key_w[fpos / 16] = {key_w[fpos / 16][59:0], 4'(n)};
                        fpos++;
                    end
                    else if (c != plp_pkg::CH_COLON) malformed = 1;
                    else
                    begin
                        phase = plp_pkg::PH_COUNTER;
                        fpos = 0;
                    end
                end
                plp_pkg::PH_COUNTER:
                begin
                    if (fpos < 8)
                    begin
                        n = hex_digit(c);
                        if (n >= 16)
                        begin
                            malformed = 1;
                            return;
                        end
                        counter_v = {counter_v[27:0], 4'(n)};
                        fpos++;
                    end
                    else if (c != plp_pkg::CH_COLON) malformed = 1;
                    else
                    begin
                        phase = plp_pkg::PH_NAME;
                        fpos = 0;
                    end
                end
                plp_pkg::PH_NAME: name_char(c);
                default: malformed = 1;
            endcase
        endfunction

        function void push_status(logic [1:0] st);
            plp_word_t w;
            w = '{status: st, slot: '0, counter: '0, word_index: '0, data_word: '0, last: 1'b1};
            pending_words.push_back(w);
            statuses++;
            clear_line();
        endfunction

        // Note one accepted request and queue the words it causes.
        function void note_request(logic deadline, logic [7:0] c);
            plp_word_t w;
            if (deadline)
            begin
                if (line_len == 0) push_status(plp_pkg::ST_TIMEOUT);
                return;
            end
            if (c == plp_pkg::CH_LF || c == plp_pkg::CH_CR)
            begin
                if (line_len == 0) return;
                if (!text_ended && !malformed && phase == plp_pkg::PH_NAME) name_close();
                if (malformed || phase != plp_pkg::PH_NAME)
                begin
                    push_status(plp_pkg::ST_MALFORMED);
                    return;
                end
                for (int k = 0; k < 5; k++)
                begin
                    w.status = plp_pkg::ST_RECORD;
                    w.slot = slot_v[3:0];
                    w.counter = counter_v;
                    w.word_index = 3'(k);
                    w.data_word = '0;
                    if (k < 2) w.data_word = key_w[k];
                    else
                        for (int r = 0; r < 8; r++)
                            w.data_word = {w.data_word[55:0], name_b[(k - 2) * 8 + r]};
                    w.last = (k == 4);
                    pending_words.push_back(w);
                end
                records++;
                clear_line();
                return;
            end
            line_len++;
            if (!malformed && !text_ended)
            begin
                if (c == 8'h00)
                begin
                    text_ended = 1;
                    if (phase == plp_pkg::PH_NAME) name_close();
                end
                else
                begin
                    parse_char(c);
                end
            end
            if (line_len >= LINE_CAP - 1) push_status(plp_pkg::ST_OVERFLOW);
        endfunction

        function void report(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
            errors++;
        endfunction

        // Check one accepted result word against the oldest expectation.
        function void check_word(logic [111:0] d, logic lst);
            plp_word_t w;
            if (pending_words.size() == 0)
            begin
                report("unexpected word", d[63:0], '0);
                return;
            end
            w = pending_words.pop_front();
            words_checked++;
            if (d[1:0] != w.status) report("status", d[1:0], w.status);
            if (d[5:2] != w.slot) report("slot", d[5:2], w.slot);
            if (d[37:6] != w.counter) report("counter", d[37:6], w.counter);
            if (d[40:38] != w.word_index) report("word_index", d[40:38], w.word_index);
            if (d[104:41] != w.data_word) report("data_word", d[104:41], w.data_word);
            if (lst != w.last) report("last", lst, w.last);
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;    // [7:0] rx_byte
    logic         s_axis_tuser;    // [0] func
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [111:0] m_axis_tdata;    // [1:0] status, [5:2] slot, [37:6] counter,
                                   // [40:38] word_index, [104:41] data_word
    logic         m_axis_tlast;

    line_scoreboard sb;
    int tx_idle_pct;
    int rx_idle_pct;
    int requests_sent;
    int quiet_cycles;

    provisioning_line_parser #(
        .SLOT_COUNT(SLOTS),
        .LINE_CAPACITY(LINE_CAP)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Random backpressure on the result side
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);

    // Sample both handshakes at the edge; outputs and drives change only after it.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready) sb.note_request(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata, m_axis_tlast);
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_MAX)
        begin
            $display("watchdog expired with %0d words outstanding", sb.pending_words.size());
            $display("status: fail");
            $finish;
        end
    end

    // Hand one request to the parser and hold it until it is taken.
    task automatic send_request(logic deadline, logic [7:0] c);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= deadline;
        s_axis_tdata <= c;
        do @(posedge clk); while (!s_axis_tready);
        requests_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_request(1'b0, s[i]);
    endtask

    function automatic logic [7:0] hex_char();
        logic [7:0] d;
        d = 8'($urandom_range(15));
        if (d < 10) return "0" + d;
        return 8'(($urandom_range(1) ? "a" : "A") + d - 10);
    endfunction

    // Build a well-formed line with random content, line end included.
    function automatic void build_line(ref logic [7:0] q[$]);
        int n;
        logic [7:0] c;
        q = {"P", "R", "O", "V", ":", 8'("0" + $urandom_range(SLOTS - 1)), ":"};
        for (int i = 0; i < 32; i++) q.push_back(hex_char());
        q.push_back(plp_pkg::CH_COLON);
        for (int i = 0; i < 8; i++) q.push_back(hex_char());
        q.push_back(plp_pkg::CH_COLON);
        n = $urandom_range(30);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(6))
                0: c = plp_pkg::CH_PERCENT;
                1: c = plp_pkg::CH_PLUS;
                2, 3: c = hex_char();
                4: c = 8'($urandom_range(8'h7e, 8'h20));
                5: c = 8'($urandom_range(255));
                default: c = 8'($urandom_range("z", "a"));
            endcase
            if (c == plp_pkg::CH_CR || c == plp_pkg::CH_LF ||
                (c == 8'h00 && $urandom_range(3) != 0)) c = "x";
            q.push_back(c);
        end
        q.push_back($urandom_range(1) ? plp_pkg::CH_CR : plp_pkg::CH_LF);
    endfunction

    // Mostly good lines, the rest broken lines, noise, deadlines and overflows.
    task automatic random_lines(int target);
        logic [7:0] q[$];
        int stop_at;
        int kind;
        stop_at = requests_sent + target;
        while (requests_sent < stop_at)
        begin
            kind = $urandom_range(99);
            build_line(q);
            if (kind >= 65 && kind < 80)
            begin
                // corrupt one character, or cut the line short
                if ($urandom_range(1)) q[$urandom_range(q.size() - 2)] = 8'($urandom_range(255));
                else q = {q[0:$urandom_range(q.size() - 2)], plp_pkg::CH_CR};
            end
            else if (kind >= 80 && kind < 88)
            begin
                q = {};
                repeat ($urandom_range(12, 1)) q.push_back(8'($urandom_range(255)));
                q.push_back(plp_pkg::CH_LF);
            end
            else if (kind >= 88 && kind < 94)
            begin
                q = {};
                send_request(1'b1, 8'($urandom_range(255)));
            end
            else if (kind >= 94 && kind < 97)
            begin
                // deadline in the middle of a line is ignored
                send_request(1'b0, "P");
                send_request(1'b1, 8'($urandom_range(255)));
            end
            else if (kind >= 97)
            begin
                q = {};
                repeat (LINE_CAP + 4) q.push_back(8'($urandom_range(8'h7e, 8'h20)));
                q.push_back(plp_pkg::CH_CR);
            end
            foreach (q[i]) send_request(1'b0, q[i]);
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        tx_idle_pct = 37;
        rx_idle_pct = 54;
        requests_sent = 0;
        quiet_cycles = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: timeout, empty line ends, a clean record, escapes, bad fields and an overflow
        send_request(1'b1, 8'hff);
        send_text("\r\n");
        send_text({"PROV:3:FFFFFFFFFFFFFFFFffffffffffffffff:FFFFFFFF:",
                   "a+b%41%zz%4g%%2\r"});
        send_text("PROV:2:0123456789abcdefABCDEF0123456789:00000001:x%4\r");
        send_text("PROV:2:0123456789abcdefABCDEF0123456789:00000001:");
        send_request(1'b0, 8'h00);
        send_text("tail%41\n");
        send_text("PROV:4:\n");
        send_text("PROV::\r");
        send_text("PROV:0:0g\n");
        send_text("PROX\n");
        send_text("P");
        send_request(1'b1, 8'h00);
        send_request(1'b0, plp_pkg::CH_CR);
        repeat (LINE_CAP) send_request(1'b0, 8'h80);
        send_request(1'b0, plp_pkg::CH_LF);

        // Random, in three idling regimes
        random_lines(20);
        tx_idle_pct = 54;
        rx_idle_pct = 37;
        random_lines(20);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_lines(20);

        s_axis_tvalid <= 1'b0;
        while (sb.pending_words.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("sent %0d requests; %0d records and %0d status results, %0d words checked",
                 requests_sent, sb.records, sb.statuses, sb.words_checked);
        $display("covered timeouts, empty line ends, malformed fields, escapes and overflows");
        if (sb.errors == 0 && sb.pending_words.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
